>>> rtl/psdc_pkg.sv
package psdc_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned PROD_P_W  = ERR_W + GAIN_W + 1;
  localparam int unsigned PROD_I_W  = INTEG_W + GAIN_W + 1;
  localparam int unsigned SUM_W     = 52;
  localparam int unsigned FRAC_SH   = 13;
  localparam int unsigned QUO_W     = SUM_W - FRAC_SH;
  localparam int unsigned DUTY_X_W  = DATA_W + 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] DUTY_MAX     = 16'sd31129;
  localparam logic signed [DATA_W-1:0] DUTY_MIN_ABS = 16'sd4915;
  localparam logic [GAIN_W-1:0]        KP_RESET     = 32'd268435;
  localparam logic [GAIN_W-1:0]        KI_RESET     = 32'd26844;
  localparam logic signed [PROD_I_W-1:0] PROD_LIM   = 65'sd1 <<< 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 2'd0,
    REG_KP     = 2'd1,
    REG_KI     = 2'd2,
    REG_MANUAL = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
  } work_t;

endpackage

>>> rtl/pi_speed_duty_controller_core.sv
// an accepted word passes the queue, then the product, sum, clamp and duty registers
// throughput: one word per cycle unless the output stalls, set by the single-cycle
// integral and duty update loops; the queue between front and back lets input words
// land while an output word is held; a word taken while manual duty is nonzero changes
// no state and gives no result; reset: gains and registers return to their defaults,
// integral, fwd and rev duties clear, queue and pipeline empty; output duty not reset
module pi_speed_duty_controller_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [psdc_pkg::DATA_W-1:0]    s_axis_tdata_i,  // measured_speed
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [psdc_pkg::DATA_W-1:0]    m_axis_tdata_o,  // duty_q15
  input  logic                           cfg_we_i,
  input  logic [psdc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psdc_pkg::GAIN_W-1:0]    cfg_data_i
);
  import psdc_pkg::*;

  logic signed [DATA_W-1:0] target_q, target_d;
  logic signed [DATA_W-1:0] manual_q, manual_d;
  logic [GAIN_W-1:0]        kp_q, kp_d;
  logic [GAIN_W-1:0]        ki_q, ki_d;
  logic                     clr_integ;
  cfg_t                     cfg;

  logic  q_push, q_full, q_pop, q_valid;
  work_t q_wdata, q_rdata;

  always_comb begin
    target_d  = target_q;
    manual_d  = manual_q;
    kp_d      = kp_q;
    ki_d      = ki_q;
    clr_integ = 1'b0;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TARGET: begin
          target_d  = cfg_data_i[DATA_W-1:0];
          clr_integ = 1'b1;
        end
        REG_KP:     kp_d     = cfg_data_i;
        REG_KI:     ki_d     = cfg_data_i;
        REG_MANUAL: manual_d = cfg_data_i[DATA_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      manual_q <= '0;
      kp_q     <= KP_RESET;
      ki_q     <= KI_RESET;
    end else begin
      target_q <= target_d;
      manual_q <= manual_d;
      kp_q     <= kp_d;
      ki_q     <= ki_d;
    end
  end

  assign cfg = '{target: target_q, kp: kp_q, ki: ki_q};

  psdc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .target_i        (target_q),
    .manual_i        (manual_q),
    .clr_integ_i     (clr_integ),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  psdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  psdc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/psdc_front.sv
module psdc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [psdc_pkg::DATA_W-1:0]        s_axis_tdata_i,  // measured_speed
  input  logic signed [psdc_pkg::DATA_W-1:0] target_i,
  input  logic signed [psdc_pkg::DATA_W-1:0] manual_i,
  input  logic                               clr_integ_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output psdc_pkg::work_t                    q_data_o
);
  import psdc_pkg::*;

  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [ERR_W-1:0]   err;
  logic signed [DATA_W-1:0]  meas;
  logic                      accept;

  assign meas            = s_axis_tdata_i;
  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && !q_full_i;
  assign q_push_o        = accept && (manual_i == '0);

  always_comb begin
    err       = {target_i[DATA_W-1], target_i} - {meas[DATA_W-1], meas};
    integ_sum = {integ_q[INTEG_W-1], integ_q}
              + {{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err};
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  always_comb begin
    if (clr_integ_i) begin
      integ_d = '0;
    end else if (q_push_o) begin
      integ_d = integ_sat;
    end else begin
      integ_d = integ_q;
    end
  end

  assign q_data_o = '{err: err, integ: integ_sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      integ_q <= integ_d;
    end
  end

endmodule

>>> rtl/psdc_queue.sv
module psdc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psdc_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output psdc_pkg::work_t pop_data_o
);
  import psdc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

>>> rtl/psdc_back.sv
module psdc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psdc_pkg::cfg_t              cfg_i,
  input  logic                        q_valid_i,
  input  psdc_pkg::work_t             q_data_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [psdc_pkg::DATA_W-1:0] m_axis_tdata_o  // duty_q15
);
  import psdc_pkg::*;

  localparam logic signed [DUTY_X_W-1:0] MAX_X  = DUTY_X_W'(DUTY_MAX);
  localparam logic signed [DUTY_X_W-1:0] MIN_X  = DUTY_X_W'(DUTY_MIN_ABS);
  localparam logic signed [DUTY_X_W-1:0] S16_HI = 18'sd32767;
  localparam logic signed [DUTY_X_W-1:0] S16_LO = -18'sd32768;
  localparam logic signed [QUO_W-1:0]    MV_HI  = QUO_W'(DUTY_MAX);
  localparam logic signed [QUO_W-1:0]    MV_LO  = -QUO_W'(DUTY_MAX);

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;

  logic signed [ERR_W-1:0]    err_s;
  logic signed [INTEG_W-1:0]  integ_s;
  logic signed [PROD_P_W-1:0] p_prod, p1_q;
  logic signed [PROD_I_W-1:0] i_prod, i1_q;
  logic signed [SUM_W-1:0]    i_cl, sum_d, sum2_q;
  logic signed [SUM_W-1:0]    sum_rnd;
  logic signed [QUO_W-1:0]    quo;
  logic signed [DATA_W-1:0]   mv_d, mv3_q;

  logic signed [DATA_W-1:0]   fwd_q, fwd_d, rev_q, rev_d, duty_q, duty_d;
  logic signed [DUTY_X_W-1:0] fsum, rsum;

  assign en_o    = !vo_q || m_axis_tready_i;
  assign en3     = !v3_q || en_o;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign q_pop_o = q_valid_i && en1;

  assign err_s   = q_data_i.err;
  assign integ_s = q_data_i.integ;
  assign p_prod  = err_s * $signed({1'b0, cfg_i.kp});
  assign i_prod  = integ_s * $signed({1'b0, cfg_i.ki});

  always_comb begin
    if (i1_q > PROD_LIM) begin
      i_cl = SUM_W'(PROD_LIM);
    end else if (i1_q < -PROD_LIM) begin
      i_cl = -SUM_W'(PROD_LIM);
    end else begin
      i_cl = i1_q[SUM_W-1:0];
    end
    sum_d = {{(SUM_W - PROD_P_W){p1_q[PROD_P_W-1]}}, p1_q} + i_cl;
  end

  // truncate toward zero
  always_comb begin
    sum_rnd = sum2_q + (sum2_q[SUM_W-1] ? SUM_W'((1 << FRAC_SH) - 1) : '0);
    quo     = QUO_W'(sum_rnd >>> FRAC_SH);
    if (quo > MV_HI) begin
      mv_d = DUTY_MAX;
    end else if (quo < MV_LO) begin
      mv_d = -DUTY_MAX;
    end else begin
      mv_d = quo[DATA_W-1:0];
    end
  end

  always_comb begin
    fsum   = DUTY_X_W'(fwd_q) + DUTY_X_W'(mv3_q);
    rsum   = DUTY_X_W'(rev_q) + DUTY_X_W'(mv3_q);
    fwd_d  = fwd_q;
    rev_d  = rev_q;
    duty_d = duty_q;
    if (cfg_i.target == '0) begin
      if (fsum > S16_HI) begin
        fwd_d = 16'sd32767;
      end else if (fsum < S16_LO) begin
        fwd_d = -16'sd32768;
      end else begin
        fwd_d = fsum[DATA_W-1:0];
      end
      duty_d = fwd_d;
    end else if (!cfg_i.target[DATA_W-1]) begin
      if (fsum <= MIN_X) begin
        fwd_d = DUTY_MIN_ABS;
      end else if (fsum >= MAX_X) begin
        fwd_d = DUTY_MAX;
      end else begin
        fwd_d = fsum[DATA_W-1:0];
      end
      duty_d = fwd_d;
    end else begin
      if (rsum >= -MIN_X) begin
        rev_d = -DUTY_MIN_ABS;
      end else if (rsum <= -MAX_X) begin
        rev_d = -DUTY_MAX;
      end else begin
        rev_d = rsum[DATA_W-1:0];
      end
      duty_d = rev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vo_q  <= 1'b0;
      fwd_q <= '0;
      rev_q <= '0;
    end else begin
      if (en1) begin
        v1_q <= q_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en_o) begin
        vo_q <= v3_q;
      end
      if (v3_q && en_o) begin
        fwd_q <= fwd_d;
        rev_q <= rev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q <= p_prod;
      i1_q <= i_prod;
    end
    if (en2) begin
      sum2_q <= sum_d;
    end
    if (en3) begin
      mv3_q <= mv_d;
    end
    if (v3_q && en_o) begin
      duty_q <= duty_d;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = duty_q;

  a_fwd_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (cfg_i.target > 0)) |->
      (duty_q >= DUTY_MIN_ABS && duty_q <= DUTY_MAX))
    else $error("forward duty outside band");

  a_rev_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (cfg_i.target < 0)) |->
      (duty_q <= -DUTY_MIN_ABS && duty_q >= -DUTY_MAX))
    else $error("reverse duty outside band");

endmodule
